### rtl/chbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbq_pkg: shared types and microcode for the cascaded high-pass dc blocker
// control word layout, step codes, register indexes and the microcode rom
// ----------------------------------------------------------------------------
package chbq_pkg;

  // fixed arithmetic format
  localparam int unsigned COEF_BITS    = 32;  // coefficient operand, signed q2.x
  localparam int unsigned ACC_FRAC     = 20;  // fraction bits below the sample lsb
  localparam int unsigned ST_BITS      = 48;  // delay state width
  localparam int unsigned PROD_LIM_EXP = 52;  // scaled products clamp to +-2^52
  localparam int unsigned SCW          = 54;  // scaled product width
  localparam int unsigned AW           = 56;  // accumulator width
  localparam int unsigned XW           = 66;  // widened product for scaling

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_COEF_B0 = 2'd1,
    REG_COEF_A1 = 2'd2,
    REG_COEF_A2 = 2'd3
  } reg_idx_e;

  // multiplier coefficient select
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_B0,
    MUL_A1,
    MUL_A2
  } mul_e;

  // accumulator operations
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_T0_D0,    // acc = t0 + d0
    ALU_D1_T0X2,  // acc = d1 - 2*t0
    ALU_ACC_SC,   // acc = acc - sc
    ALU_T0_SC     // acc = t0 - sc
  } alu_e;

  // microprogram steps
  typedef enum logic [3:0] {
    S_MB0    = 4'd0,
    S_SC_T0  = 4'd1,
    S_ACC_D0 = 4'd2,
    S_RND    = 4'd3,
    S_MA1    = 4'd4,
    S_SC_A1  = 4'd5,
    S_SUB_A1 = 4'd6,
    S_WR_D0  = 4'd7,
    S_WR_D1  = 4'd8,
    S_OUT    = 4'd9
  } step_e;

  typedef struct packed {
    mul_e  mul;
    logic  scale_t0;
    logic  scale_sc;
    alu_e  alu;
    logic  round_x;
    logic  wr_d0;
    logic  wr_d1;
    logic  stage_jmp;  // next section: jump to target, or fall through after the last
    logic  emit;
    step_e target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   load;       // sample taken this cycle
    logic   load_zero;  // filter off: result is zero
    logic   clear;      // config write clears delay state
  } dp_ctl_t;

  localparam ucode_t UC_NOP = '{
    mul:       MUL_NONE,
    scale_t0:  1'b0,
    scale_sc:  1'b0,
    alu:       ALU_NOP,
    round_x:   1'b0,
    wr_d0:     1'b0,
    wr_d1:     1'b0,
    stage_jmp: 1'b0,
    emit:      1'b0,
    target:    S_MB0
  };

  // microcode rom, one control word per step
  function automatic ucode_t ucode(step_e pc);
    ucode_t uc;
    uc = UC_NOP;
    case (pc)
      S_MB0: begin
        uc.mul = MUL_B0;
      end
      S_SC_T0: begin
        uc.scale_t0 = 1'b1;
      end
      S_ACC_D0: begin
        uc.alu = ALU_T0_D0;
      end
      S_RND: begin
        uc.round_x = 1'b1;
        uc.alu     = ALU_D1_T0X2;
      end
      S_MA1: begin
        uc.mul = MUL_A1;
      end
      S_SC_A1: begin
        uc.scale_sc = 1'b1;
        uc.mul      = MUL_A2;
      end
      S_SUB_A1: begin
        uc.alu      = ALU_ACC_SC;
        uc.scale_sc = 1'b1;
      end
      S_WR_D0: begin
        uc.wr_d0 = 1'b1;
        uc.alu   = ALU_T0_SC;
      end
      S_WR_D1: begin
        uc.wr_d1     = 1'b1;
        uc.mul       = MUL_B0;
        uc.stage_jmp = 1'b1;
        uc.target    = S_SC_T0;
      end
      S_OUT: begin
        uc.emit = 1'b1;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
    return uc;
  endfunction

endpackage
`default_nettype wire

### rtl/chbq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbq_ctrl: microprogram sequencer
// step counter, section counter and input handshake; drives the datapath
// ----------------------------------------------------------------------------
module chbq_ctrl import chbq_pkg::*; #(
  parameter int unsigned NUM_STAGES = 2,
  localparam int unsigned SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic          enable_i,
  input  wire logic          clear_i,
  input  wire logic          out_free_i,
  output      dp_ctl_t       ctl_o,
  output      logic [SW-1:0] stage_o
);

  localparam logic [SW-1:0] LAST_STAGE = SW'(NUM_STAGES - 1);

  logic          busy_q;
  step_e         pc_q;
  logic [SW-1:0] stage_q;
  ucode_t        uc;
  logic          accept;

  assign uc         = busy_q ? ucode(pc_q) : UC_NOP;
  assign accept     = in_valid_i && !busy_q;
  assign in_ready_o = !busy_q;
  assign stage_o    = stage_q;

  assign ctl_o = '{uc: uc, load: accept, load_zero: !enable_i, clear: clear_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= S_MB0;
      stage_q <= '0;
    end else if (accept) begin
      busy_q  <= 1'b1;
      pc_q    <= enable_i ? S_MB0 : S_OUT;
      stage_q <= '0;
    end else if (busy_q) begin
      if (uc.emit) begin
        if (out_free_i) begin
          busy_q <= 1'b0;
        end
      end else if (uc.stage_jmp) begin
        if (stage_q == LAST_STAGE) begin
          stage_q <= '0;
          pc_q    <= step_e'(pc_q + 4'd1);
        end else begin
          stage_q <= stage_q + SW'(1);
          pc_q    <= uc.target;
        end
      end else begin
        pc_q <= step_e'(pc_q + 4'd1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/chbq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbq_datapath: shared multiplier, product scaler, accumulator and delay state
// executes one control word per cycle for the current section
// ----------------------------------------------------------------------------
module chbq_datapath import chbq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 30,
  parameter int unsigned NUM_STAGES     = 2,
  localparam int unsigned SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dp_ctl_t                       ctl_i,
  input  wire logic [SW-1:0]                 stage_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_b0_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_a1_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_a2_i,
  output      logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int unsigned PW = SAMPLE_BITS + COEF_BITS;
  localparam int K  = int'(COEF_FRAC_BITS) - int'(ACC_FRAC);
  localparam int unsigned KR = (K >= 0) ? K : 0;
  localparam int unsigned KL = (K < 0) ? -K : 0;

  localparam logic signed [XW-1:0] LIM     = XW'(1) << PROD_LIM_EXP;
  localparam logic signed [XW-1:0] PRE_LIM = LIM >>> KL;
  localparam logic signed [AW-1:0] RND     = AW'(1) << (ACC_FRAC - 1);
  localparam logic signed [AW-1:0] Y_MAX   = (AW'(1) << (SAMPLE_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] Y_MIN   = -(AW'(1) << (SAMPLE_BITS - 1));
  localparam logic signed [AW-1:0] ST_MAX  = (AW'(1) << (ST_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] ST_MIN  = -(AW'(1) << (ST_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [SCW-1:0]         t0_q;
  logic signed [SCW-1:0]         sc_q;
  logic signed [AW-1:0]          acc_q;
  logic signed [ST_BITS-1:0]     d0_q [NUM_STAGES];
  logic signed [ST_BITS-1:0]     d1_q [NUM_STAGES];

  logic signed [COEF_BITS-1:0]   coef_m;
  logic signed [PW-1:0]          prod_d;
  logic signed [XW-1:0]          pext;
  logic signed [XW-1:0]          psh;
  logic signed [XW-1:0]          pcl;
  logic signed [SCW-1:0]         pscaled;
  logic signed [ST_BITS-1:0]     d0_rd;
  logic signed [ST_BITS-1:0]     d1_rd;
  logic signed [AW-1:0]          acc_d;
  logic signed [AW-1:0]          rnd;
  logic signed [AW-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [ST_BITS-1:0]     st_sat;

  assign y_o   = x_q;
  assign d0_rd = d0_q[stage_i];
  assign d1_rd = d1_q[stage_i];

  // coefficient select and multiplier
  always_comb begin
    case (ctl_i.uc.mul)
      MUL_B0:  coef_m = coef_b0_i;
      MUL_A1:  coef_m = coef_a1_i;
      MUL_A2:  coef_m = coef_a2_i;
      default: coef_m = coef_b0_i;
    endcase
  end

  assign prod_d = x_q * coef_m;

  // bring product to 20 fraction bits with floor, clamp to +-2^52
  always_comb begin
    pext = prod_q;
    psh  = pext >>> KR;
    if (psh > PRE_LIM) begin
      pcl = PRE_LIM;
    end else if (psh < -PRE_LIM) begin
      pcl = -PRE_LIM;
    end else begin
      pcl = psh;
    end
    pscaled = SCW'(pcl <<< KL);
  end

  // accumulator
  always_comb begin
    case (ctl_i.uc.alu)
      ALU_T0_D0:   acc_d = AW'(t0_q) + AW'(d0_rd);
      ALU_D1_T0X2: acc_d = AW'(d1_rd) - (AW'(t0_q) <<< 1);
      ALU_ACC_SC:  acc_d = acc_q - AW'(sc_q);
      ALU_T0_SC:   acc_d = AW'(t0_q) - AW'(sc_q);
      default:     acc_d = acc_q;
    endcase
  end

  // round half up and saturate to the sample range
  always_comb begin
    rnd    = acc_q + RND;
    y_full = rnd >>> ACC_FRAC;
    if (y_full > Y_MAX) begin
      y_sat = SAMPLE_BITS'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_sat = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_sat = SAMPLE_BITS'(y_full);
    end
  end

  // saturate new delay value to 48 bits
  always_comb begin
    if (acc_q > ST_MAX) begin
      st_sat = ST_BITS'(ST_MAX);
    end else if (acc_q < ST_MIN) begin
      st_sat = ST_BITS'(ST_MIN);
    end else begin
      st_sat = ST_BITS'(acc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= ctl_i.load_zero ? '0 : sample_i;
    end else if (ctl_i.uc.round_x) begin
      x_q <= y_sat;
    end
    if (ctl_i.uc.mul != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (ctl_i.uc.scale_t0) begin
      t0_q <= pscaled;
    end
    if (ctl_i.uc.scale_sc) begin
      sc_q <= pscaled;
    end
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        d0_q[i] <= '0;
        d1_q[i] <= '0;
      end
    end else if (ctl_i.clear) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        d0_q[i] <= '0;
        d1_q[i] <= '0;
      end
    end else begin
      if (ctl_i.uc.wr_d0) begin
        d0_q[stage_i] <= st_sat;
      end
      if (ctl_i.uc.wr_d1) begin
        d1_q[stage_i] <= st_sat;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/cascaded_highpass_biquad_dc_block_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_highpass_biquad_dc_block_unit: dc blocker, cascaded high-pass biquads
// NUM_STAGES identical transposed direct form ii sections with b1 = -2*b0
// ----------------------------------------------------------------------------
// Each sample passes through NUM_STAGES identical second-order high-pass
// sections; every section output is rounded half up and saturated to
// SAMPLE_BITS and feeds both the next section and its own feedback. The three
// products of each section (b1 and b2 reuse the b0 product) run on one shared
// SAMPLE_BITSx32 multiplier under control of a small microprogram, so a sample
// occupies the block until its result enters the output register, and the next
// one is accepted only after that. With the filter disabled a sample skips the
// section steps and gives out_sample 0 with filtered 0.
// A finished result sits in an output register, so the next sample is taken
// while the result waits for the consumer. Writing any coefficient or the
// enable register clears all delay state at once; write configuration only
// while no sample is in flight.
// ----------------------------------------------------------------------------
module cascaded_highpass_biquad_dc_block_unit import chbq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 30,
  parameter int unsigned NUM_STAGES     = 2,
  localparam int unsigned TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [COEF_BITS-1:0] cfg_wdata_i,
  // sample input
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [TDW-1:0]       s_axis_tdata,   // [SAMPLE_BITS-1:0] in_sample
  // result output
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [TDW-1:0]       m_axis_tdata,   // [SAMPLE_BITS-1:0] out_sample
  output      logic [0:0]           m_axis_tuser    // [0] filtered
);

  localparam int unsigned SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  // configuration registers
  logic                        enable_q;
  logic [COEF_BITS-2:0]        coef_b0_q;
  logic signed [COEF_BITS-1:0] coef_a1_q;
  logic [COEF_BITS-2:0]        coef_a2_q;

  // output register
  logic                        out_valid_q;
  logic [SAMPLE_BITS-1:0]      out_sample_q;
  logic                        out_filt_q;

  dp_ctl_t                     ctl;
  logic [SW-1:0]               stage;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                        out_free;
  logic                        emit;

  // output slot free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = ctl.uc.emit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      coef_b0_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        REG_COEF_B0: coef_b0_q <= cfg_wdata_i[COEF_BITS-2:0];
        REG_COEF_A1: coef_a1_q <= cfg_wdata_i;
        REG_COEF_A2: coef_a2_q <= cfg_wdata_i[COEF_BITS-2:0];
        default:     enable_q  <= enable_q;
      endcase
    end
  end

  chbq_ctrl #(
    .NUM_STAGES (NUM_STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .enable_i   (enable_q),
    .clear_i    (cfg_we_i),      // every index in range clears the delays
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .stage_o    (stage)
  );

  chbq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NUM_STAGES     (NUM_STAGES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .stage_i   (stage),
    .sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .coef_b0_i ({1'b0, coef_b0_q}),
    .coef_a1_i (coef_a1_q),
    .coef_a2_i ({1'b0, coef_a2_q}),
    .y_o       (y)
  );

  // result register, drained by the output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sample_q <= y;
      out_filt_q   <= enable_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'(out_sample_q);
  assign m_axis_tuser  = out_filt_q;

endmodule
`default_nettype wire
